// File: rtl/fte_pkg.sv
// Package for the Fenwick tree engine: command codes, sequencer states, field widths.
// No dependencies; used by fenwick_tree_engine_top.
package fte_pkg;

  localparam int DATA_W  = 32;
  localparam int FIELD_W = 11;
  localparam int CMD_W   = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PREFIX = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RANGE  = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_HI,
    ST_WALK_LO,
    ST_SET_PREP,
    ST_ADD,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_B1,
    ST_B2_RI,
    ST_B2_RJ,
    ST_DONE
  } state_t;

endpackage

// File: rtl/fte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fenwick_tree_engine_top.sv
// Fenwick tree engine top level: command sequencer around one cell RAM.
// Depends on fte_pkg and fte_ram.
//
// Binary indexed tree over SIZE signed 32-bit cells (indices 1..SIZE) held in one
// RAM with a registered read. One command is worked at a time; each gives one
// result transaction with a wrapping 32-bit sum and an error flag. After reset
// the block sweeps the RAM to zero before in_ready rises. Raw load adds value to
// the addressed cell; add walks up the index chain from i; prefix sum walks down
// from i; range sum walks down from last and from first-1; set is a prefix pair
// followed by an add. Build runs a running prefix pass and then a difference pass.
// The cost of each command is set by the index chain it walks, one RAM read per
// step (two reads per cell in the second build pass). A rejected command goes
// straight to the done state. A finished result waits in the output register
// while the next command is accepted.
module fenwick_tree_engine_top #(
  parameter int SIZE = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic [10:0]        first_index,
  input  logic [10:0]        last_index,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sum,
  output logic               error
);

  localparam int IW = $clog2(SIZE + 1);
  localparam int XW = IW + 1;
  localparam int EW = (XW > fte_pkg::FIELD_W) ? XW : fte_pkg::FIELD_W;
  localparam logic [XW-1:0] SIZE_X = XW'(SIZE);

  fte_pkg::state_t state, state_next;

  logic [XW-1:0] idx, idx_next;
  logic [XW-1:0] lo_idx, lo_idx_next;
  logic [XW-1:0] first_q, first_q_next;
  logic [IW-1:0] wr_addr, wr_addr_next;
  logic          rd_pend, rd_pend_next;
  logic [fte_pkg::DATA_W-1:0] acc, acc_next;
  logic [fte_pkg::DATA_W-1:0] delta, delta_next;
  logic [fte_pkg::CMD_W-1:0]  cmd_q, cmd_q_next;
  logic          err_q, err_q_next;
  logic          out_valid_next;
  logic [fte_pkg::DATA_W-1:0] sum_next;
  logic          error_next;

  logic                       mem_we;
  logic [IW-1:0]              mem_waddr, mem_raddr;
  logic [fte_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  logic [EW-1:0] first_ext, last_ext;
  logic [XW-1:0] first_x, last_x;
  logic          first_ok, last_ok, order_ok;
  logic [XW-1:0] idx_low, idx_clr, idx_inc;

  assign first_ext = EW'(first_index);
  assign last_ext  = EW'(last_index);
  assign first_x   = first_ext[XW-1:0];
  assign last_x    = last_ext[XW-1:0];
  assign first_ok  = (first_index != '0) && (32'(first_index) <= 32'(SIZE));
  assign last_ok   = 32'(last_index) <= 32'(SIZE);
  assign order_ok  = first_index <= last_index;

  // lowbit and the two chain steps
  assign idx_low = idx & (~idx + 1'b1);
  assign idx_clr = idx & (idx - 1'b1);
  assign idx_inc = idx + idx_low;

  assign in_ready = (state == fte_pkg::ST_IDLE);

  fte_ram #(
    .WIDTH(fte_pkg::DATA_W),
    .DEPTH(SIZE + 1)
  ) u_cells (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    lo_idx_next    = lo_idx;
    first_q_next   = first_q;
    wr_addr_next   = wr_addr;
    rd_pend_next   = rd_pend;
    acc_next       = acc;
    delta_next     = delta;
    cmd_q_next     = cmd_q;
    err_q_next     = err_q;
    out_valid_next = out_valid & ~out_ready;
    sum_next       = sum;
    error_next     = error;
    mem_we         = 1'b0;
    mem_waddr      = wr_addr;
    mem_raddr      = idx[IW-1:0];
    mem_wdata      = mem_rdata + delta;

    case (state)
      fte_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[IW-1:0];
        mem_wdata = '0;
        if (idx == SIZE_X) begin
          idx_next   = '0;
          state_next = fte_pkg::ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      fte_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_q_next   = cmd;
          acc_next     = '0;
          delta_next   = value;
          err_q_next   = 1'b0;
          rd_pend_next = 1'b0;
          first_q_next = first_x;
          idx_next     = first_x;
          lo_idx_next  = '0;
          case (cmd)
            fte_pkg::CMD_LOAD: begin
              if (first_ok) state_next = fte_pkg::ST_LOAD_RD;
              else begin
                err_q_next = 1'b1;
                state_next = fte_pkg::ST_DONE;
              end
            end
            fte_pkg::CMD_BUILD: begin
              idx_next   = XW'(1);
              state_next = fte_pkg::ST_B1;
            end
            fte_pkg::CMD_ADD: begin
              if (first_ok) state_next = fte_pkg::ST_ADD;
              else begin
                err_q_next = 1'b1;
                state_next = fte_pkg::ST_DONE;
              end
            end
            fte_pkg::CMD_SET: begin
              lo_idx_next = first_x - 1'b1;
              if (first_ok) state_next = fte_pkg::ST_WALK_HI;
              else begin
                err_q_next = 1'b1;
                state_next = fte_pkg::ST_DONE;
              end
            end
            fte_pkg::CMD_PREFIX: begin
              if (first_ok) state_next = fte_pkg::ST_WALK_HI;
              else begin
                err_q_next = 1'b1;
                state_next = fte_pkg::ST_DONE;
              end
            end
            fte_pkg::CMD_RANGE: begin
              idx_next    = last_x;
              lo_idx_next = first_x - 1'b1;
              if ((first_index != '0) && last_ok && order_ok) begin
                state_next = fte_pkg::ST_WALK_HI;
              end else begin
                err_q_next = 1'b1;
                state_next = fte_pkg::ST_DONE;
              end
            end
            default: begin
              err_q_next = 1'b1;
              state_next = fte_pkg::ST_DONE;
            end
          endcase
        end
      end
      fte_pkg::ST_WALK_HI: begin
        if (rd_pend) acc_next = acc + mem_rdata;
        if (idx != '0) begin
          idx_next     = idx_clr;
          rd_pend_next = 1'b1;
        end else begin
          idx_next     = lo_idx;
          rd_pend_next = 1'b0;
          state_next   = fte_pkg::ST_WALK_LO;
        end
      end
      fte_pkg::ST_WALK_LO: begin
        if (rd_pend) acc_next = acc - mem_rdata;
        if (idx != '0) begin
          idx_next     = idx_clr;
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          state_next   = (cmd_q == fte_pkg::CMD_SET) ? fte_pkg::ST_SET_PREP : fte_pkg::ST_DONE;
        end
      end
      fte_pkg::ST_SET_PREP: begin
        delta_next = delta - acc;
        acc_next   = '0;
        idx_next   = first_q;
        state_next = fte_pkg::ST_ADD;
      end
      fte_pkg::ST_ADD: begin
        // write of the previous cell overlaps the read of the next one up the chain
        mem_we = rd_pend;
        if (idx <= SIZE_X) begin
          wr_addr_next = idx[IW-1:0];
          idx_next     = idx_inc;
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          state_next   = fte_pkg::ST_DONE;
        end
      end
      fte_pkg::ST_LOAD_RD: begin
        wr_addr_next = idx[IW-1:0];
        state_next   = fte_pkg::ST_LOAD_WR;
      end
      fte_pkg::ST_LOAD_WR: begin
        mem_we     = 1'b1;
        state_next = fte_pkg::ST_DONE;
      end
      fte_pkg::ST_B1: begin
        // running prefix sum, in place
        mem_wdata = acc + mem_rdata;
        if (rd_pend) begin
          mem_we   = 1'b1;
          acc_next = acc + mem_rdata;
        end
        if (idx <= SIZE_X) begin
          wr_addr_next = idx[IW-1:0];
          idx_next     = idx + 1'b1;
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          idx_next     = SIZE_X;
          state_next   = fte_pkg::ST_B2_RI;
        end
      end
      fte_pkg::ST_B2_RI: begin
        // cell[i] = P[i] - P[i - lowbit(i)], walking down so lower cells are still P
        mem_wdata = acc - mem_rdata;
        mem_we    = rd_pend;
        rd_pend_next = 1'b0;
        if (idx != '0) begin
          wr_addr_next = idx[IW-1:0];
          state_next   = fte_pkg::ST_B2_RJ;
        end else begin
          acc_next   = '0;
          state_next = fte_pkg::ST_DONE;
        end
      end
      fte_pkg::ST_B2_RJ: begin
        acc_next     = mem_rdata;
        mem_raddr    = idx_clr[IW-1:0];
        idx_next     = idx - 1'b1;
        rd_pend_next = 1'b1;
        state_next   = fte_pkg::ST_B2_RI;
      end
      fte_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          sum_next       = acc;
          error_next     = err_q;
          state_next     = fte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fte_pkg::ST_CLEAR;
      idx       <= '0;
      rd_pend   <= 1'b0;
      acc       <= '0;
      err_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      rd_pend   <= rd_pend_next;
      acc       <= acc_next;
      err_q     <= err_q_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo_idx  <= lo_idx_next;
    first_q <= first_q_next;
    wr_addr <= wr_addr_next;
    delta   <= delta_next;
    cmd_q   <= cmd_q_next;
    sum     <= sum_next;
    error   <= error_next;
  end

  // a rejected command never reports a sum
  a_err_zero_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> sum == '0)
    else $error("error result carries nonzero sum");

  // cell 0 is only written by the clearing sweep
  a_no_cell0_write: assert property (@(posedge clk) disable iff (rst)
    mem_we && state != fte_pkg::ST_CLEAR |-> mem_waddr != '0)
    else $error("write to cell 0 outside clearing sweep");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> 32'(mem_waddr) <= 32'(SIZE))
    else $error("RAM write beyond SIZE");

  // no read may be left in flight when a command finishes
  a_no_pend_done: assert property (@(posedge clk) disable iff (rst)
    state == fte_pkg::ST_DONE || state == fte_pkg::ST_IDLE |-> !rd_pend)
    else $error("pending read at end of command");

  // a result register load only happens from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == fte_pkg::ST_DONE)
    else $error("result raised outside done state");

endmodule
